### rtl/core/pcas_pkg.sv
// Shared types, state codes and exponent tables of the pixel class scoring unit.
`default_nettype none
package pcas_pkg;

	localparam int unsigned Q16_ONE = 65536;
	localparam int unsigned EXP_CUT = 12;

	typedef struct packed {
		logic binary;
		logic last;
	} cmd_flags_t;

	typedef enum logic [1:0] {
		OP_BIN,
		OP_SCALE,
		OP_ADD
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_EXP1,
		ST_EXP2,
		ST_APPLY,
		ST_FIN,
		ST_DIV,
		ST_RES,
		ST_EMIT
	} state_t;

	typedef enum logic {
		CFG_CLASS_COUNT = 1'b0,
		CFG_THRESHOLD   = 1'b1
	} cfg_reg_t;

	localparam logic [16:0] E_INT [16] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
		17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0};
	localparam logic [16:0] E_HI [16] = '{
		17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51040, 17'd47947, 17'd45042,
		17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
		17'd27319, 17'd25664};
	localparam logic [16:0] E_LO [16] = '{
		17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
		17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291,
		17'd62048, 17'd61806};

endpackage
`default_nettype wire

### rtl/core/pcas_if.sv
// Handshake interfaces for the logit, result and configuration channels.
`default_nettype none
interface pcas_logit_if #(parameter int LOGIT_BITS = 16);
	logic valid;
	logic ready;
	logic signed [LOGIT_BITS-1:0] logit;
	modport source (output valid, output logit, input ready);
	modport sink (input valid, input logit, output ready);
endinterface

interface pcas_result_if;
	logic valid;
	logic ready;
	logic [7:0] label;
	logic [15:0] score;
	modport source (output valid, output label, output score, input ready);
	modport sink (input valid, input label, input score, output ready);
endinterface

interface pcas_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [16:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/pcas_front.sv
// Front end: tracks the class position and tags each logit as binary or last of a pixel.
`default_nettype none
module pcas_front #(
	parameter int MAX_CLASSES = 256,
	parameter int LOGIT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [LOGIT_BITS-1:0] in_logit,
	input  wire logic [8:0]                   class_count,
	output logic                              cmd_valid,
	input  wire logic                         cmd_ready,
	output logic signed [LOGIT_BITS-1:0]      cmd_logit,
	output logic [7:0]                        cmd_index,
	output pcas_pkg::cmd_flags_t              cmd_flags
);
	localparam int POS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
	localparam int CW = $clog2(MAX_CLASSES + 1) + 10;

	logic [POS_W-1:0] pos_q;
	logic [CW-1:0] cnt;
	logic binary;
	logic last;

	always_comb begin
		if (class_count == 9'd0) begin
			cnt = CW'(1);
		end else if (CW'(class_count) > CW'(MAX_CLASSES)) begin
			cnt = CW'(MAX_CLASSES);
		end else begin
			cnt = CW'(class_count);
		end
		binary = (cnt == CW'(1));
		last = binary || ((CW'(pos_q) + CW'(1)) >= cnt);
	end

	assign in_ready = cmd_ready;
	assign cmd_valid = in_valid;
	assign cmd_logit = in_logit;
	assign cmd_index = 8'(pos_q);
	assign cmd_flags = '{binary: binary, last: last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_valid && cmd_ready) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/pcas_queue.sv
// Small register queue between the front end and the arithmetic back end.
`default_nettype none
module pcas_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != (PW+1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/pcas_back.sv
// Back end: exponent, rescaled softmax sum, bit-serial division and result register.
`default_nettype none
module pcas_back #(
	parameter int MAX_CLASSES = 256,
	parameter int LOGIT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire logic signed [LOGIT_BITS-1:0] cmd_logit,
	input  wire logic [7:0]                   cmd_index,
	input  wire pcas_pkg::cmd_flags_t         cmd_flags,
	input  wire logic [16:0]                  threshold,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic [7:0]                        res_label,
	output logic [15:0]                       res_score
);
	localparam int L = LOGIT_BITS;
	localparam int SW = 17 + $clog2(MAX_CLASSES);
	localparam logic [L-1:0] INVALID = {1'b1, {(L-1){1'b0}}};

	pcas_pkg::state_t state_q, state_d;
	pcas_pkg::op_t op_q;
	pcas_pkg::cmd_flags_t flags_q;
	logic signed [L-1:0] v_q;
	logic [7:0] idx_q;
	logic signed [L-1:0] max_q;
	logic [7:0] best_q;
	logic [SW-1:0] sum_q;
	logic [L-1:0] u_q;
	logic [16:0] r1_q;
	logic [16:0] e_q;
	logic [32:0] num_q;
	logic [SW-1:0] den_q;
	logic [SW-1:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0] div_cnt_q;
	logic [7:0] pend_class_q;
	logic [15:0] pend_score_q;
	logic out_valid_q;
	logic [7:0] out_class_q;
	logic [15:0] out_score_q;

	logic v_ok;
	logic v_gt;
	logic [L:0] diff_up;
	logic [L:0] diff_dn;
	logic [L-1:0] abs_v;
	logic [3:0] n4;
	logic exp_zero;
	logic [33:0] prod1;
	logic [33:0] prod2;
	logic [16:0] r1;
	logic [16:0] e_next;
	logic [SW+16:0] prod3;
	logic [SW-1:0] sum_scaled;
	logic [17:0] d_bin;
	logic [32:0] num_bin;
	logic [32:0] num_mc;
	logic [SW:0] trial;
	logic trial_ge;
	logic [16:0] one_minus;
	logic emit;

	always_comb begin
		v_ok = (v_q != INVALID);
		v_gt = (v_q > max_q);
		diff_up = (L+1)'(v_q) - (L+1)'(max_q);
		diff_dn = (L+1)'(max_q) - (L+1)'(v_q);
		abs_v = v_q[L-1] ? L'(-v_q) : L'(v_q);
		n4 = 4'(u_q >> 8);
		exp_zero = ((u_q >> 8) >= L'(pcas_pkg::EXP_CUT));
		prod1 = 34'(pcas_pkg::E_INT[n4]) * 34'(pcas_pkg::E_HI[u_q[7:4]]);
		r1 = 17'((prod1 + 34'd32768) >> 16);
		prod2 = 34'(r1_q) * 34'(pcas_pkg::E_LO[u_q[3:0]]);
		e_next = exp_zero ? 17'd0 : 17'((prod2 + 34'd32768) >> 16);
		prod3 = (SW+17)'(sum_q) * (SW+17)'(e_q);
		sum_scaled = SW'((prod3 + (SW+17)'(32768)) >> 16) + SW'(pcas_pkg::Q16_ONE);
		d_bin = 18'(e_q) + 18'(pcas_pkg::Q16_ONE);
		num_bin = (v_q[L-1] ? {e_q, 16'd0} : 33'h1_0000_0000) + 33'(d_bin >> 1);
		num_mc = 33'h1_0000_0000 + 33'(sum_q >> 1);
		trial = {rem_q, num_q[16]};
		trial_ge = (trial >= {1'b0, den_q});
		one_minus = 17'(pcas_pkg::Q16_ONE) - quo_q;
		emit = !out_valid_q || res_ready;
	end

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			pcas_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = pcas_pkg::ST_PREP;
				end
			end
			pcas_pkg::ST_PREP: begin
				if (flags_q.binary) begin
					state_d = v_ok ? pcas_pkg::ST_EXP1 : pcas_pkg::ST_EMIT;
				end else if (v_ok && !(v_gt && sum_q == '0)) begin
					state_d = pcas_pkg::ST_EXP1;
				end else begin
					state_d = pcas_pkg::ST_FIN;
				end
			end
			pcas_pkg::ST_EXP1: state_d = pcas_pkg::ST_EXP2;
			pcas_pkg::ST_EXP2: state_d = pcas_pkg::ST_APPLY;
			pcas_pkg::ST_APPLY: begin
				state_d = (op_q == pcas_pkg::OP_BIN) ? pcas_pkg::ST_DIV : pcas_pkg::ST_FIN;
			end
			pcas_pkg::ST_FIN: begin
				if (!flags_q.last) begin
					state_d = pcas_pkg::ST_IDLE;
				end else if (max_q == INVALID || sum_q == '0) begin
					state_d = pcas_pkg::ST_EMIT;
				end else begin
					state_d = pcas_pkg::ST_DIV;
				end
			end
			pcas_pkg::ST_DIV: begin
				if (div_cnt_q == 5'd16) begin
					state_d = pcas_pkg::ST_RES;
				end
			end
			pcas_pkg::ST_RES: state_d = pcas_pkg::ST_EMIT;
			pcas_pkg::ST_EMIT: begin
				if (emit) begin
					state_d = pcas_pkg::ST_IDLE;
				end
			end
			default: state_d = pcas_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= INVALID;
			best_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pcas_pkg::ST_EMIT && emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pcas_pkg::ST_PREP: begin
					if (flags_q.binary) begin
						max_q <= INVALID;
						best_q <= '0;
						sum_q <= '0;
					end else if (v_ok && v_gt && sum_q == '0) begin
						sum_q <= SW'(pcas_pkg::Q16_ONE);
						max_q <= v_q;
						best_q <= idx_q;
					end
				end
				pcas_pkg::ST_APPLY: begin
					if (op_q == pcas_pkg::OP_SCALE) begin
						sum_q <= sum_scaled;
						max_q <= v_q;
						best_q <= idx_q;
					end else if (op_q == pcas_pkg::OP_ADD) begin
						sum_q <= sum_q + SW'(e_q);
					end
				end
				pcas_pkg::ST_FIN: begin
					if (flags_q.last) begin
						max_q <= INVALID;
						best_q <= '0;
						sum_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pcas_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					v_q <= cmd_logit;
					idx_q <= cmd_index;
					flags_q <= cmd_flags;
				end
			end
			pcas_pkg::ST_PREP: begin
				pend_class_q <= '0;
				pend_score_q <= '0;
				if (flags_q.binary) begin
					u_q <= abs_v;
					op_q <= pcas_pkg::OP_BIN;
				end else if (v_gt) begin
					u_q <= L'(diff_up);
					op_q <= pcas_pkg::OP_SCALE;
				end else begin
					u_q <= L'(diff_dn);
					op_q <= pcas_pkg::OP_ADD;
				end
			end
			pcas_pkg::ST_EXP1: r1_q <= r1;
			pcas_pkg::ST_EXP2: e_q <= e_next;
			pcas_pkg::ST_APPLY: begin
				num_q <= num_bin;
				den_q <= SW'(d_bin);
				rem_q <= SW'(num_bin[32:17]);
				quo_q <= '0;
				div_cnt_q <= '0;
			end
			pcas_pkg::ST_FIN: begin
				pend_class_q <= best_q;
				pend_score_q <= '0;
				num_q <= num_mc;
				den_q <= sum_q;
				rem_q <= SW'(num_mc[32:17]);
				quo_q <= '0;
				div_cnt_q <= '0;
			end
			pcas_pkg::ST_DIV: begin
				num_q <= num_q << 1;
				rem_q <= trial_ge ? SW'(trial - {1'b0, den_q}) : SW'(trial);
				quo_q <= {quo_q[15:0], trial_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			pcas_pkg::ST_RES: begin
				if (op_q == pcas_pkg::OP_BIN && quo_q < threshold) begin
					pend_class_q <= 8'd0;
					pend_score_q <= one_minus[16] ? 16'hFFFF : one_minus[15:0];
				end else begin
					pend_class_q <= (op_q == pcas_pkg::OP_BIN) ? 8'd1 : pend_class_q;
					pend_score_q <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
				end
			end
			pcas_pkg::ST_EMIT: begin
				if (emit) begin
					out_class_q <= pend_class_q;
					out_score_q <= pend_score_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = out_valid_q;
	assign res_label = out_class_q;
	assign res_score = out_score_q;

	a_sum_live: assert property (@(posedge clk) disable iff (!arst_n)
		(max_q != INVALID) |-> (sum_q != '0))
		else $error("softmax sum is empty while a maximum is held");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcas_pkg::ST_DIV) |-> (div_cnt_q <= 5'd16))
		else $error("divider ran past its last quotient bit");
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcas_pkg::ST_FIN && flags_q.last) |=>
		(state_q == pcas_pkg::ST_DIV || state_q == pcas_pkg::ST_EMIT))
		else $error("last class of a pixel did not lead to a result");
	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcas_pkg::ST_FIN && flags_q.last) |=> (sum_q == '0))
		else $error("pixel state not cleared after its last class");
endmodule
`default_nettype wire

### rtl/core/pixel_class_argmax_softmax_score_unit.sv
// Top level of the per-pixel argmax unit with softmax or sigmoid confidence.
//
//  Channel  Role   Request contents
//  logits   sink   logit (signed Q8.8), one per class, in class order
//  results  source label, score (Q0.16), one per pixel
//  cfg      sink   index 0 class_count, index 1 foreground threshold; always ready
//
// A logit goes through accept, prepare, two exponent multiplies, sum update and close-out;
// an invalid logit or the first valid one of a pixel goes from prepare to close-out. The
// last class of a pixel adds divider steps, rounding and result load, or only the result
// load if no logit was valid; a binary item skips close-out, an invalid one goes to result load.
// A four-entry queue lets the front end keep accepting logits while the back end works,
// and the back end stalls only while the result register is full.
// Reset clears the pixel state and sets class_count to 2 and the threshold to 32768.
`default_nettype none
module pixel_class_argmax_softmax_score_unit #(
	parameter int MAX_CLASSES = 256,
	parameter int LOGIT_BITS = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pcas_logit_if.sink logits,
	pcas_result_if.source results,
	pcas_cfg_if.sink   cfg
);
	localparam int QW = LOGIT_BITS + 10;
	localparam int QDEPTH = 4;

	logic [8:0] class_count_q;
	logic [16:0] threshold_q;

	logic f_valid;
	logic f_ready;
	logic signed [LOGIT_BITS-1:0] f_logit;
	logic [7:0] f_index;
	pcas_pkg::cmd_flags_t f_flags;

	logic b_valid;
	logic b_ready;
	logic [QW-1:0] b_data;
	pcas_pkg::cmd_flags_t b_flags;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= 9'd2;
			threshold_q <= 17'd32768;
		end else if (cfg.valid) begin
			unique case (pcas_pkg::cfg_reg_t'(cfg.index))
				pcas_pkg::CFG_CLASS_COUNT: class_count_q <= cfg.data[8:0];
				pcas_pkg::CFG_THRESHOLD:   threshold_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	pcas_front #(
		.MAX_CLASSES(MAX_CLASSES),
		.LOGIT_BITS(LOGIT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(logits.valid),
		.in_ready(logits.ready),
		.in_logit(logits.logit),
		.class_count(class_count_q),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd_logit(f_logit),
		.cmd_index(f_index),
		.cmd_flags(f_flags)
	);

	pcas_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data({f_logit, f_index, f_flags}),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(b_data)
	);

	assign b_flags = pcas_pkg::cmd_flags_t'(b_data[1:0]);

	pcas_back #(
		.MAX_CLASSES(MAX_CLASSES),
		.LOGIT_BITS(LOGIT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd_logit(b_data[QW-1:10]),
		.cmd_index(b_data[9:2]),
		.cmd_flags(b_flags),
		.threshold(threshold_q),
		.res_valid(results.valid),
		.res_ready(results.ready),
		.res_label(results.label),
		.res_score(results.score)
	);
endmodule
`default_nettype wire

### tb/sv/tb_pcas_checker.sv
// Checker that predicts pixel class and confidence results and compares them with the block.
`timescale 1ns / 1ps
`default_nettype none
module tb_pcas_checker (
	input wire logic clk,
	input wire logic arst_n,
	pcas_logit_if.sink logits,
	pcas_result_if.sink results,
	pcas_cfg_if.sink cfg,
	output int unsigned mismatches,
	output int unsigned pending
);
	localparam int unsigned CLASS_LIMIT = 256;
	localparam int unsigned E_INT_T [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
		22, 8, 3, 1};
	localparam int unsigned E_HI_T [16] = '{65536, 61565, 57835, 54331, 51040, 47947, 45042,
		42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	localparam int unsigned E_LO_T [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
		63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

	typedef struct packed {
		logic [7:0] label;
		logic [15:0] score;
	} pixel_result_t;

	pixel_result_t expected_results[$];
	logic signed [16:0] peak_logit;
	logic [7:0] peak_class;
	logic [63:0] exp_total;
	logic [8:0] class_idx;
	logic [8:0] classes_per_pixel;
	logic [16:0] fg_threshold;

	function automatic logic [63:0] neg_exp(input logic [63:0] u);
		logic [63:0] r;
		if ((u >> 8) >= 12)
			return 0;
		r = (64'(E_INT_T[u >> 8]) * E_HI_T[(u >> 4) & 15] + 32768) >> 16;
		r = (r * E_LO_T[u & 15] + 32768) >> 16;
		return r;
	endfunction

	function automatic logic [15:0] clip16(input logic [63:0] v);
		return v > 65535 ? 16'hFFFF : v[15:0];
	endfunction

	task automatic clear_pixel();
		peak_logit = -17'sd32768;
		peak_class = 0;
		exp_total = 0;
		class_idx = 0;
	endtask

	task automatic predict_logit(input logic signed [15:0] x);
		int unsigned cnt;
		logic valid_logit;
		logic [63:0] e, d, p;
		logic signed [16:0] v;
		pixel_result_t r;
		v = x;
		valid_logit = (x != 16'sh8000);
		cnt = classes_per_pixel;
		if (cnt == 0)
			cnt = 1;
		if (cnt > CLASS_LIMIT)
			cnt = CLASS_LIMIT;
		if (cnt == 1) begin
			clear_pixel();
			if (!valid_logit) begin
				r = '0;
			end else begin
				if (v >= 0) begin
					e = neg_exp(64'(v));
					d = 65536 + e;
					p = ((64'd1 << 32) + (d >> 1)) / d;
				end else begin
					e = neg_exp(64'(-v));
					d = 65536 + e;
					p = (e * 65536 + (d >> 1)) / d;
				end
				if (p >= fg_threshold) begin
					r.label = 1;
					r.score = clip16(p);
				end else begin
					r.label = 0;
					r.score = clip16(65536 - p);
				end
			end
			expected_results = {expected_results, r};
			return;
		end
		if (valid_logit) begin
			if (v > peak_logit) begin
				if (exp_total != 0)
					exp_total = (exp_total * neg_exp(64'(v - peak_logit)) + 32768) >> 16;
				exp_total += 65536;
				peak_logit = v;
				peak_class = class_idx[7:0];
			end else begin
				exp_total += neg_exp(64'(peak_logit - v));
			end
		end
		if (class_idx + 1 >= cnt) begin
			r.label = peak_class;
			if (peak_logit == -17'sd32768 || exp_total == 0)
				r.score = 0;
			else
				r.score = clip16(((64'd1 << 32) + (exp_total >> 1)) / exp_total);
			expected_results = {expected_results, r};
			clear_pixel();
		end else begin
			class_idx++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			clear_pixel();
			classes_per_pixel = 2;
			fg_threshold = 32768;
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == pcas_pkg::CFG_CLASS_COUNT)
					classes_per_pixel = cfg.data[8:0];
				else
					fg_threshold = cfg.data;
			end
			if (logits.valid && logits.ready)
				predict_logit(logits.logit);
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: label %0d score %0d",
							results.label, results.score);
				end else begin
					want = expected_results.pop_front();
					if (want.label !== results.label || want.score !== results.score) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result mismatch: expected label %0d score %0d, got %0d %0d",
								want.label, want.score, results.label, results.score);
					end
				end
			end
		end
		pending = expected_results.size();
	end
endmodule
`default_nettype wire

### tb/sv/tb_pixel_class_argmax_softmax_score_unit.sv
// Stimulus and verdict for the pixel class argmax and softmax score unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_pixel_class_argmax_softmax_score_unit;
	localparam int unsigned STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned idle_cycles;
	int unsigned burst_left;
	int unsigned stall_mode;
	logic [8:0] cur_classes;

	pcas_logit_if #(.LOGIT_BITS(16)) logits ();
	pcas_result_if results ();
	pcas_cfg_if cfg ();

	pixel_class_argmax_softmax_score_unit dut (
		.clk(clk), .arst_n(arst_n), .logits(logits), .results(results), .cfg(cfg));

	tb_pcas_checker checker_i (
		.clk(clk), .arst_n(arst_n), .logits(logits), .results(results), .cfg(cfg),
		.mismatches(mismatches), .pending(pending));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		case (stall_mode)
			0: results.ready <= 1'b1;
			1: results.ready <= ($urandom_range(3) != 0);
			default: results.ready <= ($urandom_range(3) == 0);
		endcase
		if ($urandom_range(199) == 0)
			stall_mode <= $urandom_range(2);
	end

	always @(posedge clk) begin
		if ((logits.valid && logits.ready) || (results.valid && results.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_logit(input logic [15:0] x);
		if (burst_left == 0) begin
			logits.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		logits.valid <= 1'b1;
		logits.logit <= x;
		do @(posedge clk); while (!logits.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		logits.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input pcas_pkg::cfg_reg_t idx, input logic [16:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		if (idx == pcas_pkg::CFG_CLASS_COUNT)
			cur_classes = val[8:0];
	endtask

	function automatic logic [15:0] rand_logit();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(65535));
			3: return 16'h8001;
			default: return 16'($signed($urandom_range(2400)) - 1200);
		endcase
	endfunction

	initial begin
		int unsigned sent;
		int unsigned n;
		logic [8:0] counts [7];
		counts = '{9'd2, 9'd3, 9'd5, 9'd1, 9'd0, 9'd300, 9'd256};
		arst_n = 0;
		burst_left = 0;
		cur_classes = 2;
		logits.valid = 0;
		logits.logit = 0;
		cfg.valid = 0;
		cfg.index = pcas_pkg::CFG_CLASS_COUNT;
		cfg.data = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Default two-class pixels: ties, invalid marks, extremes.
		send_logit(16'h0100); send_logit(16'h0100);
		send_logit(16'h8000); send_logit(16'h8000);
		send_logit(16'h7FFF); send_logit(16'h8001);
		send_logit(16'h8000); send_logit(16'hFF00);
		send_logit(16'h0000); send_logit(16'h0C00);
		// Binary mode with thresholds at the extremes.
		write_reg(pcas_pkg::CFG_CLASS_COUNT, 17'd1);
		send_logit(16'h0000); send_logit(16'h8000);
		send_logit(16'h7FFF); send_logit(16'h8001);
		write_reg(pcas_pkg::CFG_THRESHOLD, 17'd65536);
		send_logit(16'h7FFF); send_logit(16'h0200);
		write_reg(pcas_pkg::CFG_THRESHOLD, 17'd0);
		send_logit(16'h8001); send_logit(16'hF000);
		// Count lowered in the middle of a pixel.
		write_reg(pcas_pkg::CFG_CLASS_COUNT, 17'd5);
		send_logit(16'h0010); send_logit(16'h0020);
		drain();
		write_reg(pcas_pkg::CFG_CLASS_COUNT, 17'd2);
		send_logit(16'h0030);
		write_reg(pcas_pkg::CFG_CLASS_COUNT, 17'd4);
		send_logit(16'h0040); send_logit(16'h0050);
		write_reg(pcas_pkg::CFG_CLASS_COUNT, 17'd1);
		send_logit(16'h0060);
		sent = 0;
		while (sent < 1400) begin
			write_reg(pcas_pkg::CFG_CLASS_COUNT, {8'd0, counts[$urandom_range(6)]});
			if ($urandom_range(3) == 0)
				write_reg(pcas_pkg::CFG_THRESHOLD, 17'($urandom_range(65536)));
			n = (cur_classes == 0) ? 1 : (cur_classes > 256 ? 256 : cur_classes);
			n = (n > 8) ? n : n * $urandom_range(40, 8);
			repeat (n) begin
				send_logit(rand_logit());
				sent++;
			end
			if ($urandom_range(4) == 0)
				drain();
		end
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
